// ----- hdl/bh_pkg.sv -----
// ----------------------------------------------------------------------------
// bh_pkg: shared definitions of the byte histogram
// Bin geometry, field widths, command codes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bh_pkg;

  localparam int NUM_BINS    = 256;
  localparam int COUNT_WIDTH = 32;
  localparam int BIN_IDX_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int OUT_CNT_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;    // latch the accepted item and start the bin read
    logic clear_all;  // drop every bin back to zero
    logic bin_write;  // write the incremented count back
    logic out_load;   // move the bin count into the output register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd;  // command of the item in progress
    logic             out_free;
  } stat_t;

endpackage

// ----- hdl/bh_if.sv -----
// ----------------------------------------------------------------------------
// bh_in_if / bh_out_if: item channels of the byte histogram
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bh_in_if;
  logic                     valid;
  logic                     ready;
  logic [bh_pkg::CMD_W-1:0]  command;
  logic [bh_pkg::BYTE_W-1:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface bh_out_if;
  logic                        valid;
  logic                        ready;
  logic [bh_pkg::BYTE_W-1:0]    bin_index;
  logic [bh_pkg::OUT_CNT_W-1:0] bin_count;

  modport source (output valid, output bin_index, output bin_count, input ready);
  modport sink   (input valid, input bin_index, input bin_count, output ready);
endinterface

// ----- hdl/byte_histogram.sv -----
// ----------------------------------------------------------------------------
// byte_histogram: 256-bin byte value histogram
// Counts byte occurrences in 32-bit bins, clears all bins on command and
// returns the count of one bin on a read command.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on in_i, a valid/ready channel carrying a command and a byte.
// A clear command zeroes every bin, a count command adds one to the bin of
// the byte (wrapping at the counter width), and a read command returns one
// item on out_o with the bin index and its count. The unused command code is
// taken and dropped without effect.
// A clear or an unused command does not hold the block busy; a count or a
// read holds it busy while the single-port bin memory does its registered
// read and then the write back or the result load. A read result is loaded
// from the registered bin read into the output register once that is free.
// The result sits in an output register, so the next item is accepted while
// a result waits. If the receiver holds off ready and a second read is
// ready to load, the block waits with in_i not ready until the register
// frees. A clear takes effect at once through per-bin valid flags.
// Reset: all bins read as zero and out_o holds no item; no sweep is needed.
// ----------------------------------------------------------------------------
module byte_histogram (
  input  logic clk_i,
  input  logic rst_ni,
  bh_in_if.sink    in_i,
  bh_out_if.source out_o
);
  import bh_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  in_ready;
  logic  out_valid;
  logic [BYTE_W-1:0]    out_index;
  logic [OUT_CNT_W-1:0] out_count;

  bh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.command),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  bh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_cmd_i    (in_i.command),
    .in_byte_i   (in_i.byte_value),
    .ctl_i       (ctl),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_index_o (out_index),
    .out_count_o (out_count)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.bin_index = out_index;
  assign out_o.bin_count = out_count;

endmodule

// ----- hdl/bh_ctrl.sv -----
// ----------------------------------------------------------------------------
// bh_ctrl: sequencer of the byte histogram
// Accepts one item at a time and steps the datapath through the bin read,
// the write back of a count, or the hand-off of a read result.
// ----------------------------------------------------------------------------
module bh_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [bh_pkg::CMD_W-1:0] in_cmd_i,
  output logic                     in_ready_o,
  input  bh_pkg::stat_t            stat_i,
  output bh_pkg::ctl_t             ctl_o
);
  import bh_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d           = state_q;
    ctl_o             = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctl_o.capture = 1'b1;
          case (cmd_e'(in_cmd_i))
            CMD_CLEAR: ctl_o.clear_all = 1'b1;
            CMD_COUNT: state_d = ST_EXEC;
            CMD_READ:  state_d = ST_EXEC;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_EXEC: begin
        case (cmd_e'(stat_i.cmd))
          CMD_COUNT: begin
            ctl_o.bin_write = 1'b1;
            state_d         = ST_IDLE;
          end
          CMD_READ: begin
            // Wait here while an earlier result still sits unclaimed.
            if (stat_i.out_free) begin
              ctl_o.out_load = 1'b1;
              state_d        = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/bh_datapath.sv -----
// ----------------------------------------------------------------------------
// bh_datapath: bin memory, increment and result register
// Holds the bin counts in a single-port memory with per-bin valid flags, so
// that a clear needs no sweep of the memory; a bin without its flag reads zero.
// ----------------------------------------------------------------------------
module bh_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [bh_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [bh_pkg::BYTE_W-1:0]    in_byte_i,
  input  bh_pkg::ctl_t                 ctl_i,
  output bh_pkg::stat_t                stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bh_pkg::BYTE_W-1:0]    out_index_o,
  output logic [bh_pkg::OUT_CNT_W-1:0] out_count_o
);
  import bh_pkg::*;

  logic [COUNT_WIDTH-1:0] mem_q [NUM_BINS];
  logic [NUM_BINS-1:0]    vld_q;

  logic [CMD_W-1:0]       cmd_q;
  logic [BYTE_W-1:0]      byte_q;
  logic                   in_range_q;
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic                   rvld_q;

  logic [BIN_IDX_W-1:0]   rd_idx;
  logic [BIN_IDX_W-1:0]   wr_idx;
  logic                   in_range;
  logic [COUNT_WIDTH-1:0] cur_count;
  logic [COUNT_WIDTH-1:0] inc_count;
  logic [OUT_CNT_W+COUNT_WIDTH-1:0] cnt_ext;

  logic                   out_valid_q;
  logic [BYTE_W-1:0]      out_index_q;
  logic [OUT_CNT_W-1:0]   out_count_q;

  assign rd_idx    = in_byte_i[BIN_IDX_W-1:0];
  assign wr_idx    = byte_q[BIN_IDX_W-1:0];
  assign in_range  = ({1'b0, in_byte_i} < (BYTE_W+1)'(NUM_BINS));
  assign cur_count = (rvld_q && in_range_q) ? rdata_q : '0;
  assign inc_count = cur_count + COUNT_WIDTH'(1);
  assign cnt_ext   = {{OUT_CNT_W{1'b0}}, cur_count};

  // Item latch.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q      <= in_cmd_i;
      byte_q     <= in_byte_i;
      in_range_q <= in_range;
    end
  end

  // Bin memory: one read at capture, one write back in the following cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      rdata_q <= mem_q[rd_idx];
    end
    if (ctl_i.bin_write && in_range_q) begin
      mem_q[wr_idx] <= inc_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctl_i.capture) begin
        rvld_q <= vld_q[rd_idx];
      end
      if (ctl_i.clear_all) begin
        vld_q <= '0;
      end else if (ctl_i.bin_write && in_range_q) begin
        vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_index_q <= byte_q;
      out_count_q <= cnt_ext[OUT_CNT_W-1:0];
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_count_o = out_count_q;

endmodule

// ----- sim/byte_histogram_tb.sv -----
// ----------------------------------------------------------------------------
// byte_histogram_tb: self-checking bench for the byte histogram
// Offers clear, count, read and unused command items to the block while the
// result channel stalls at random. A local copy of all 256 bins predicts
// every read result, and each result is checked against the oldest
// outstanding read.
// ----------------------------------------------------------------------------
module byte_histogram_tb;
  import bh_pkg::*;

  // Unused command code; the block takes it and drops it without effect.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int CLK_PERIOD       = 4;
  localparam int RESET_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES    = 20;
  localparam int TIME_LIMIT       = 1_000_000;
  localparam int MAX_REPORTS      = 10;

  // Entries of the stimulus plan: real items and control markers for the
  // driver, which handles a marker as soon as it reaches it.
  typedef enum {STEP_ITEM, STEP_DRAIN, STEP_HOLD, STEP_IDLING} step_kind_e;

  typedef struct {
    step_kind_e        kind;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] byte_value;
    int                send_idle_pct;
    int                recv_stall_pct;
  } step_t;

  typedef struct {
    logic [BYTE_W-1:0]    bin_index;
    logic [OUT_CNT_W-1:0] bin_count;
  } bin_read_t;

  logic clk;
  logic rst_n;

  bh_in_if  in_ch ();
  bh_out_if out_ch ();

  byte_histogram dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  step_t     plan_q[$];
  bin_read_t reads_due[$];

  logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];

  step_t cur_item;
  bit    have_item;
  bit    item_shown;
  bit    draining;
  bit    in_taken;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    hold_requests;
  int    hold_seen;
  int    hold_left;

  int n_clear, n_count, n_read, n_unused;
  int n_checked, n_mismatch, n_in_stalls;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Driver: offers the plan one item at a time. Once valid is raised it stays
  // high until the item is taken; idle gaps only fall before an item.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    step_t nxt;
    bit    offer;
    if (rst_n) begin
      if (in_taken) begin
        have_item  = 1'b0;
        item_shown = 1'b0;
      end
      if (draining && reads_due.size() == 0) draining = 1'b0;
      while (!have_item && !draining && plan_q.size() > 0) begin
        nxt = plan_q.pop_front();
        case (nxt.kind)
          STEP_ITEM: begin
            cur_item  = nxt;
            have_item = 1'b1;
          end
          STEP_DRAIN: draining = 1'b1;
          STEP_HOLD:  hold_requests <= hold_requests + 1;
          default: begin
            send_idle_pct  = nxt.send_idle_pct;
            recv_stall_pct <= nxt.recv_stall_pct;
          end
        endcase
      end
      offer = have_item && (item_shown || $urandom_range(99) >= send_idle_pct);
      item_shown = offer;
      in_ch.valid      <= offer;
      in_ch.command    <= cur_item.command;
      in_ch.byte_value <= cur_item.byte_value;
    end
  end

  // --------------------------------------------------------------------------
  // Result side ready: random stalls, plus a long hold-off on request during
  // which the block has to fill up and push back on its input.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic flag_mismatch(input string msg);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: updates the bin copy on every accepted item and checks every
  // accepted result against the oldest outstanding read.
  // --------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    bin_read_t want;
    bin_read_t got;
    if (!rst_n) begin
      in_taken <= 1'b0;
      for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && !in_ch.ready) n_in_stalls++;

      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.command)
          CMD_CLEAR: begin
            n_clear++;
            for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
          end
          CMD_COUNT: begin
            n_count++;
            // The counter simply wraps when it passes its top value.
            if (int'(in_ch.byte_value) < NUM_BINS)
              bin_tally[in_ch.byte_value] = bin_tally[in_ch.byte_value] + 1'b1;
          end
          CMD_READ: begin
            n_read++;
            want.bin_index = in_ch.byte_value;
            want.bin_count = '0;
            if (int'(in_ch.byte_value) < NUM_BINS)
              want.bin_count = OUT_CNT_W'(bin_tally[in_ch.byte_value]);
            reads_due.push_back(want);
          end
          default: n_unused++;
        endcase
      end

      if (out_ch.valid && out_ch.ready) begin
        got.bin_index = out_ch.bin_index;
        got.bin_count = out_ch.bin_count;
        if (reads_due.size() == 0) begin
          flag_mismatch($sformatf("result with no read outstanding: index %0d count %0d",
                                  got.bin_index, got.bin_count));
        end else begin
          want = reads_due.pop_front();
          n_checked++;
          if (got.bin_index !== want.bin_index || got.bin_count !== want.bin_count)
            flag_mismatch($sformatf("read result: expected index %0d count %0d, got index %0d count %0d",
                                    want.bin_index, want.bin_count,
                                    got.bin_index, got.bin_count));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan
  // --------------------------------------------------------------------------
  task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] value);
    step_t s;
    s.kind           = STEP_ITEM;
    s.command        = cmd;
    s.byte_value     = value;
    s.send_idle_pct  = 0;
    s.recv_stall_pct = 0;
    plan_q.push_back(s);
  endtask

  task automatic add_marker(input step_kind_e kind, input int send_pct, input int recv_pct);
    step_t s;
    s.kind           = kind;
    s.command        = CMD_CLEAR;
    s.byte_value     = '0;
    s.send_idle_pct  = send_pct;
    s.recv_stall_pct = recv_pct;
    plan_q.push_back(s);
  endtask

  // Random traffic leaning on a few hot bins, with runs of counts on one bin
  // closed by a read of it, so that back-to-back counts on one bin get exercised.
  task automatic add_random_items(input int n);
    logic [BYTE_W-1:0] hot [4];
    logic [BYTE_W-1:0] value;
    logic [CMD_W-1:0]  cmd;
    int                added;
    int                roll;
    int                run;
    hot   = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    added = 0;
    while (added < n) begin
      value = ($urandom_range(1) == 1) ? hot[$urandom_range(3)] : BYTE_W'($urandom_range(255));
      roll  = $urandom_range(99);
      if (roll < 10) begin
        run = $urandom_range(8, 2);
        repeat (run) add_item(CMD_COUNT, value);
        add_item(CMD_READ, value);
        added += run + 1;
      end else begin
        if (roll < 12)      cmd = CMD_CLEAR;
        else if (roll < 18) cmd = CMD_UNUSED;
        else if (roll < 48) cmd = CMD_READ;
        else                cmd = CMD_COUNT;
        add_item(cmd, value);
        added++;
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.command       = CMD_CLEAR;
    in_ch.byte_value    = '0;
    out_ch.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;

    // Directed part: empty bins after reset, both ends of the byte range,
    // the unused command, back-to-back counts on one bin and a clear.
    add_marker(STEP_IDLING, 0, 0);
    add_item(CMD_READ, 8'h00);
    add_item(CMD_READ, 8'hFF);
    add_item(CMD_COUNT, 8'h00);
    add_item(CMD_COUNT, 8'hFF);
    add_item(CMD_COUNT, 8'hFF);
    add_item(CMD_READ, 8'h00);
    add_item(CMD_READ, 8'hFF);
    add_item(CMD_UNUSED, 8'hAA);
    add_item(CMD_READ, 8'hAA);
    add_item(CMD_UNUSED, 8'h55);
    add_item(CMD_COUNT, 8'h55);
    add_item(CMD_READ, 8'h55);
    repeat (4) add_item(CMD_COUNT, 8'h07);
    add_item(CMD_READ, 8'h07);
    add_item(CMD_READ, 8'h07);
    add_item(CMD_COUNT, 8'h07);
    add_item(CMD_READ, 8'h07);
    add_item(CMD_CLEAR, 8'h00);
    add_item(CMD_READ, 8'hFF);
    add_item(CMD_READ, 8'h07);
    add_item(CMD_COUNT, 8'hFF);
    add_item(CMD_READ, 8'hFF);
    add_marker(STEP_DRAIN, 0, 0);

    // Random part in idling phases; the first opens with a long hold-off
    // on the result side while items keep coming.
    add_marker(STEP_HOLD, 0, 0);
    add_random_items(200);
    add_marker(STEP_DRAIN, 0, 0);
    add_marker(STEP_IDLING, 77, 0);
    add_random_items(210);
    add_marker(STEP_DRAIN, 0, 0);
    add_marker(STEP_IDLING, 0, 77);
    add_random_items(210);
    add_marker(STEP_DRAIN, 0, 0);
    add_marker(STEP_IDLING, 6, 6);
    add_random_items(120);
    add_marker(STEP_HOLD, 0, 0);
    add_random_items(110);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (plan_q.size() > 0 || have_item || draining) @(posedge clk);
    while (reads_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d counts, %0d reads, %0d clears and %0d unused commands; %0d results checked.",
             n_count, n_read, n_clear, n_unused, n_checked);
    $display("Input held off by the block in %0d cycles; %0d mismatches.",
             n_in_stalls, n_mismatch);
    if (n_mismatch == 0 && reads_due.size() == 0) begin
      $display("byte_histogram verification clean");
    end else begin
      $display("byte_histogram verification failed");
    end
    $finish;
  end

  initial begin
    #(TIME_LIMIT);
    $display("byte_histogram verification failed");
    $finish;
  end

endmodule
